// ===== hdl/relocation_patch_unit_defines.svh =====
// Shared assertion macros. Every user has clk and rst in scope.
`ifndef RELOCATION_PATCH_UNIT_DEFINES_SVH
`define RELOCATION_PATCH_UNIT_DEFINES_SVH

// Same-cycle implication.
`define RPU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("relocation patch unit: same-cycle check failed");

// Next-cycle implication.
`define RPU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("relocation patch unit: next-cycle check failed");

`endif

// ===== hdl/rpu_pkg.sv =====
package rpu_pkg;

  localparam int WordW = 64;

  // relocation kinds as they arrive on req_type
  localparam logic [4:0] K_ABS8   = 5'd1;
  localparam logic [4:0] K_ABS16  = 5'd2;
  localparam logic [4:0] K_ABS32  = 5'd3;
  localparam logic [4:0] K_ABS64  = 5'd4;
  localparam logic [4:0] K_REL8   = 5'd5;
  localparam logic [4:0] K_REL16  = 5'd6;
  localparam logic [4:0] K_REL32  = 5'd7;
  localparam logic [4:0] K_REL64  = 5'd8;
  localparam logic [4:0] K_PLT32  = 5'd9;
  localparam logic [4:0] K_B26    = 5'd11;
  localparam logic [4:0] K_MOVW   = 5'd12;
  localparam logic [4:0] K_MOVT   = 5'd13;
  localparam logic [4:0] K_CALL26 = 5'd14;
  localparam logic [4:0] K_JUMP26 = 5'd15;
  localparam logic [4:0] K_ADR    = 5'd16;
  localparam logic [4:0] K_ADRP   = 5'd17;
  localparam logic [4:0] K_LO12   = 5'd18;
  localparam logic [4:0] K_A64ABS = 5'd19;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_SYM     = 3'd1,
    ST_UNRESOLVED  = 3'd2,
    ST_BAD_SECT    = 3'd3,
    ST_OUT_OF_SECT = 3'd4
  } status_t;

  // patch operation after classification
  typedef enum logic [3:0] {
    OP_UNH,
    OP_ABS8,
    OP_ABS16,
    OP_ABS32,
    OP_ABS64,
    OP_REL8,
    OP_REL16,
    OP_REL32,
    OP_REL64,
    OP_B26,
    OP_MOVW,
    OP_MOVT,
    OP_BR26,
    OP_ADR,
    OP_ADRP,
    OP_LO12
  } op_t;

  typedef struct packed {
    op_t              op;
    status_t          status;
    logic [WordW-1:0] sa;
    logic [WordW-1:0] pc;
    logic [WordW-1:0] old_word;
  } entry_t;

endpackage

// ===== hdl/relocation_patch_unit.sv =====
// Relocation patch unit: applies one ELF-style relocation per item and returns the patched
// little-endian word, the byte count to write back, a status and warning flags. An item can
// be accepted every cycle unless in_stall is high and results leave at one per cycle unless
// out_stall holds them. Classification and the S+A and offset checks are written into the
// queue at the accepting edge, the patch merge into the output register when out_stall lets
// the queue head go. The queue holds QUEUE_DEPTH classified items, so with the output register
// the unit absorbs QUEUE_DEPTH + 1 items while the consumer stalls before in_stall rises.
module relocation_patch_unit import rpu_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [4:0]       req_type,
  input  logic [WordW-1:0] sym_value,
  input  logic [WordW-1:0] addend,
  input  logic [WordW-1:0] patch_addr,
  input  logic [WordW-1:0] sect_base,
  input  logic [WordW-1:0] sect_size,
  input  logic             sym_in_range,
  input  logic             sym_defined,
  input  logic             sect_in_range,
  input  logic [WordW-1:0] old_word,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WordW-1:0] new_word,
  output logic [3:0]       write_bytes,
  output logic [2:0]       status,
  output logic             overflow_warn,
  output logic             unhandled_kind
);

  entry_t front_entry;
  entry_t head_entry;
  logic   head_valid;
  logic   head_ready;

  rpu_front u_front (
    .req_type      (req_type),
    .sym_value     (sym_value),
    .addend        (addend),
    .patch_addr    (patch_addr),
    .sect_base     (sect_base),
    .sect_size     (sect_size),
    .sym_in_range  (sym_in_range),
    .sym_defined   (sym_defined),
    .sect_in_range (sect_in_range),
    .old_word      (old_word),
    .entry         (front_entry)
  );

  rpu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_stall (in_stall),
    .push_data  (front_entry),
    .pop_valid  (head_valid),
    .pop_ready  (head_ready),
    .pop_data   (head_entry)
  );

  rpu_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (head_valid),
    .q_ready        (head_ready),
    .q_data         (head_entry),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .new_word       (new_word),
    .write_bytes    (write_bytes),
    .status         (status),
    .overflow_warn  (overflow_warn),
    .unhandled_kind (unhandled_kind)
  );

endmodule

// ===== hdl/rpu_front.sv =====
module rpu_front import rpu_pkg::*; (
  input  logic [4:0]       req_type,
  input  logic [WordW-1:0] sym_value,
  input  logic [WordW-1:0] addend,
  input  logic [WordW-1:0] patch_addr,
  input  logic [WordW-1:0] sect_base,
  input  logic [WordW-1:0] sect_size,
  input  logic             sym_in_range,
  input  logic             sym_defined,
  input  logic             sect_in_range,
  input  logic [WordW-1:0] old_word,
  output entry_t           entry
);

  logic [WordW-1:0] offset;
  status_t          status;
  op_t              op;

  assign offset = patch_addr - sect_base;

  // first failing check wins
  always_comb begin
    if (!sym_in_range) begin
      status = ST_BAD_SYM;
    end else if (!sym_defined) begin
      status = ST_UNRESOLVED;
    end else if (!sect_in_range) begin
      status = ST_BAD_SECT;
    end else if (!(offset < sect_size)) begin
      status = ST_OUT_OF_SECT;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    unique case (req_type) inside
      K_ABS8:            op = OP_ABS8;
      K_ABS16:           op = OP_ABS16;
      K_ABS32:           op = OP_ABS32;
      K_ABS64, K_A64ABS: op = OP_ABS64;
      K_REL8:            op = OP_REL8;
      K_REL16:           op = OP_REL16;
      K_REL32, K_PLT32:  op = OP_REL32;
      K_REL64:           op = OP_REL64;
      K_B26:             op = OP_B26;
      K_MOVW:            op = OP_MOVW;
      K_MOVT:            op = OP_MOVT;
      K_CALL26, K_JUMP26: op = OP_BR26;
      K_ADR:             op = OP_ADR;
      K_ADRP:            op = OP_ADRP;
      K_LO12:            op = OP_LO12;
      default:           op = OP_UNH;
    endcase
  end

  assign entry.op       = op;
  assign entry.status   = status;
  assign entry.sa       = sym_value + addend;
  assign entry.pc       = patch_addr;
  assign entry.old_word = old_word;

endmodule

// ===== hdl/rpu_queue.sv =====
`include "relocation_patch_unit_defines.svh"

module rpu_queue import rpu_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_stall,
  input  entry_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output entry_t pop_data
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  entry_t          mem [DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            push;
  logic            pop;

  assign push_stall = (count == CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && !push_stall;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  `RPU_ASSERT_IMPL(a_count_bound, 1'b1, count <= CntW'(DEPTH))
  `RPU_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + CntW'(1))
  `RPU_ASSERT_NEXT(a_count_down, pop && !push, count == $past(count) - CntW'(1))

endmodule

// ===== hdl/rpu_back.sv =====
`include "relocation_patch_unit_defines.svh"

module rpu_back import rpu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  entry_t           q_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [WordW-1:0] new_word,
  output logic [3:0]       write_bytes,
  output logic [2:0]       status,
  output logic             overflow_warn,
  output logic             unhandled_kind
);

  logic [WordW-1:0] old;
  logic [31:0]      ins;
  logic [WordW-1:0] sa;
  logic [WordW-1:0] rel;
  logic [25:0]      br_q;
  logic [20:0]      pg;
  logic [WordW-1:0] nw;
  logic [3:0]       nb;
  logic             warn;
  logic             unh;

  assign old = q_data.old_word;
  assign ins = q_data.old_word[31:0];
  assign sa  = q_data.sa;
  assign rel = q_data.sa - q_data.pc;
  // quotient by four, toward zero: floor plus one for a negative value with a remainder
  assign br_q = rel[27:2] + {25'd0, rel[WordW-1] & (|rel[1:0])};
  // page delta bits 32:12
  assign pg = q_data.sa[32:12] - q_data.pc[32:12];

  always_comb begin
    nw   = '0;
    nb   = '0;
    warn = 1'b0;
    unh  = 1'b0;
    if (q_data.status == ST_OK) begin
      unique case (q_data.op)
        OP_ABS8: begin
          nb = 4'd1;
          nw = {old[63:8], sa[7:0]};
        end
        OP_ABS16: begin
          nb = 4'd2;
          nw = {old[63:16], sa[15:0]};
        end
        OP_ABS32: begin
          nb = 4'd4;
          nw = {old[63:32], sa[31:0]};
        end
        OP_ABS64: begin
          nb = 4'd8;
          nw = sa;
        end
        OP_REL8: begin
          nb   = 4'd1;
          nw   = {old[63:8], rel[7:0]};
          warn = !((&rel[63:7]) || (~|rel[63:7]));
        end
        OP_REL16: begin
          nb = 4'd2;
          nw = {old[63:16], rel[15:0]};
        end
        OP_REL32: begin
          nb = 4'd4;
          nw = {old[63:32], rel[31:0]};
        end
        OP_REL64: begin
          nb = 4'd8;
          nw = rel;
        end
        OP_B26: begin
          nb = 4'd4;
          nw = {old[63:32], ins[31:24], br_q[23:0]};
        end
        OP_MOVW: begin
          nb = 4'd4;
          nw = {old[63:32], ins[31:20], sa[15:12], ins[15:12], sa[11:0]};
        end
        OP_MOVT: begin
          nb = 4'd4;
          nw = {old[63:32], ins[31:20], sa[31:28], ins[15:12], sa[27:16]};
        end
        OP_BR26: begin
          nb = 4'd4;
          nw = {old[63:32], ins[31:26], br_q};
        end
        OP_ADR: begin
          nb = 4'd4;
          nw = {old[63:32], ins[31], rel[1:0], ins[28:24], rel[20:2], ins[4:0]};
        end
        OP_ADRP: begin
          nb = 4'd4;
          nw = {old[63:32], ins[31], pg[1:0], ins[28:24], pg[20:2], ins[4:0]};
        end
        OP_LO12: begin
          nb = 4'd4;
          nw = {old[63:32], ins[31:22], sa[11:0], ins[9:0]};
        end
        default: begin
          unh = 1'b1;
        end
      endcase
    end
  end

  assign q_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_ready) begin
      out_valid <= q_valid;
    end
    if (q_ready && q_valid) begin
      new_word       <= nw;
      write_bytes    <= nb;
      status         <= q_data.status;
      overflow_warn  <= warn;
      unhandled_kind <= unh;
    end
  end

  `RPU_ASSERT_IMPL(a_err_no_write, out_valid && (status != ST_OK), write_bytes == 4'd0)
  `RPU_ASSERT_IMPL(a_unh_no_write, out_valid && unhandled_kind, write_bytes == 4'd0)

endmodule
